FILE: design/nth_root_newton_defines.svh
// Assertion macros for the n-th root block checker.
// Used by nrn_chk.sv; the macros expect i_clk and i_rst_n in scope.
`ifndef NTH_ROOT_NEWTON_DEFINES_SVH
`define NTH_ROOT_NEWTON_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRN_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NRN_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/nrn_pkg.sv
// Shared constants, item types and controller/datapath types of the n-th root block.
// No dependencies; every other file of the block but the macro header imports it.
package nrn_pkg;

    // Algorithm constants.
    localparam int ITERATIONS = 16;
    localparam int MAX_DEGREE = 16;
    localparam int FRAC_BITS  = 16;

    // Field widths.
    localparam int WORD_W = 32;
    localparam int DEG_W  = 5;
    localparam int STAT_W = 2;

    // Derived widths: divider dividend, step counters and the update sum.
    localparam int DIV_W  = WORD_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int ITER_W = $clog2(ITERATIONS + 1);
    localparam int SUM_W  = WORD_W + DEG_W + 1;

    localparam logic [WORD_W-1:0] WORD_MAX = '1;
    localparam logic [WORD_W-1:0] FX_ONE   = WORD_W'(1) << FRAC_BITS;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_INVALID = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_SAT     = STAT_W'(2);

    typedef struct packed {
        logic [WORD_W-1:0] radicand;
        logic [DEG_W-1:0]  degree;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] root;
        logic [STAT_W-1:0] status;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_POW,
        S_QSET,
        S_QDIV,
        S_USET,
        S_UDIV,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic pow_step;
        logic q_setup;
        logic div_step;
        logic q_done;
        logic u_setup;
        logic u_done;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic inval;
        logic exp_zero;
        logic p_zero;
        logic div_done;
        logic last_iter;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: design/nrn_ifs.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on nrn_pkg for the item types.
interface nrn_in_if;
    import nrn_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nrn_out_if;
    import nrn_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/nrn_dp.sv
// Datapath of the n-th root block: power multiplier, shared serial divider,
// Newton update and the result register. Depends on nrn_pkg.
module nrn_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nrn_pkg::t_in_item  i_in_data,
    input  nrn_pkg::t_dp_cmd   i_cmd,
    output nrn_pkg::t_dp_sts   o_sts,
    output logic               o_out_valid,
    output nrn_pkg::t_out_item o_out_data,
    input  logic               i_out_ready
);
    import nrn_pkg::*;

    // Working registers of one item.
    logic [WORD_W-1:0] r_x;
    logic [DEG_W-1:0]  r_n;
    logic [WORD_W-1:0] r_g;
    logic [WORD_W-1:0] r_p;
    logic [WORD_W-1:0] r_q;
    logic              r_sat;
    logic              r_inval;
    logic [DEG_W-1:0]  r_ecnt;
    logic [ITER_W-1:0] r_icnt;

    // Serial divider registers.
    logic [WORD_W-1:0] r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [WORD_W-1:0] r_dvs;
    logic [DCNT_W-1:0] r_dcnt;

    // Result register.
    logic              r_out_valid;
    t_out_item         r_out;

    logic [2*WORD_W-1:0]      prod;
    logic                     pow_sat;
    logic [WORD_W:0]          trial;
    logic                     fits;
    logic [WORD_W:0]          diff;
    logic                     quo_sat;
    logic [DEG_W-1:0]         nm1;
    logic [DEG_W+WORD_W-1:0]  wmul;
    logic [SUM_W-1:0]         sum;
    logic                     in_inval;

    // Power step: one fixed-point product, saturated to the word.
    assign prod    = r_p * r_g;
    assign pow_sat = |prod[2*WORD_W-1:WORD_W+FRAC_BITS];

    // Restoring divider: one quotient bit a cycle.
    assign trial   = {r_rem, r_quo[DIV_W-1]};
    assign fits    = (trial >= {1'b0, r_dvs});
    assign diff    = trial - {1'b0, r_dvs};
    assign quo_sat = |r_quo[DIV_W-1:WORD_W];

    // Numerator of the Newton update: (n-1)*g + q.
    assign nm1  = r_n - DEG_W'(1);
    assign wmul = nm1 * r_g;
    assign sum  = SUM_W'(wmul) + SUM_W'(r_q);

    // Zero radicand, zero degree and degrees above the maximum are rejected.
    assign in_inval = (i_in_data.radicand == '0) || (i_in_data.degree == '0) ||
                      (32'(i_in_data.degree) > MAX_DEGREE);

    // Item registers and the iteration sequence.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_in_data.radicand;
            r_n     <= i_in_data.degree;
            r_g     <= i_in_data.radicand;
            r_p     <= FX_ONE;
            r_sat   <= 1'b0;
            r_inval <= in_inval;
            r_ecnt  <= i_in_data.degree - DEG_W'(1);
            r_icnt  <= '0;
        end
        if (i_cmd.pow_step) begin
            r_p    <= pow_sat ? WORD_MAX : prod[WORD_W+FRAC_BITS-1:FRAC_BITS];
            r_ecnt <= r_ecnt - DEG_W'(1);
            if (pow_sat) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.q_setup) begin
            if (r_p == '0) begin
                // A power that underflowed to zero stands in for a division by zero.
                r_q   <= WORD_MAX;
                r_sat <= 1'b1;
            end else begin
                r_rem  <= '0;
                r_quo  <= {r_x, FRAC_BITS'(0)};
                r_dvs  <= r_p;
                r_dcnt <= DCNT_W'(DIV_W);
            end
        end
        if (i_cmd.div_step) begin
            r_rem  <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            r_quo  <= {r_quo[DIV_W-2:0], fits};
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
        if (i_cmd.q_done) begin
            r_q <= quo_sat ? WORD_MAX : r_quo[WORD_W-1:0];
            if (quo_sat) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.u_setup) begin
            r_rem  <= '0;
            r_quo  <= DIV_W'(sum);
            r_dvs  <= WORD_W'(r_n);
            r_dcnt <= DCNT_W'(DIV_W);
        end
        if (i_cmd.u_done) begin
            // The update is a weighted mean of g and q, so it fits the word.
            r_g    <= r_quo[WORD_W-1:0];
            r_icnt <= r_icnt + ITER_W'(1);
            r_p    <= FX_ONE;
            r_ecnt <= nm1;
        end
    end

    // Result register: holds a finished item until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.root   <= r_inval ? '0 : r_g;
            r_out.status <= r_inval ? ST_INVALID : (r_sat ? ST_SAT : ST_OK);
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.inval     = r_inval;
        o_sts.exp_zero  = (r_ecnt == '0);
        o_sts.p_zero    = (r_p == '0);
        o_sts.div_done  = (r_dcnt == '0);
        o_sts.last_iter = (r_icnt == ITER_W'(ITERATIONS - 1));
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/nrn_ctrl.sv
// Controller of the n-th root block: sequences power steps, divisions and updates.
// Depends on nrn_pkg for the state and command/status types.
module nrn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  nrn_pkg::t_dp_sts i_sts,
    output nrn_pkg::t_dp_cmd o_cmd
);
    import nrn_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_POW;
                end
            end
            S_POW: begin
                if (i_sts.inval) begin
                    n_state = S_FIN;
                end else if (i_sts.exp_zero) begin
                    n_state = S_QSET;
                end
            end
            S_QSET: begin
                n_state = i_sts.p_zero ? S_USET : S_QDIV;
            end
            S_QDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_USET;
                end
            end
            S_USET: begin
                n_state = S_UDIV;
            end
            S_UDIV: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.last_iter ? S_FIN : S_POW;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands and the input handshake.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_POW: begin
                o_cmd.pow_step = !i_sts.inval && !i_sts.exp_zero;
            end
            S_QSET: begin
                o_cmd.q_setup = 1'b1;
            end
            S_QDIV: begin
                o_cmd.div_step = !i_sts.div_done;
                o_cmd.q_done   = i_sts.div_done;
            end
            S_USET: begin
                o_cmd.u_setup = 1'b1;
            end
            S_UDIV: begin
                o_cmd.div_step = !i_sts.div_done;
                o_cmd.u_done   = i_sts.div_done;
            end
            S_FIN: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: design/nth_root_newton.sv
// Channel   Dir  Payload                  Handshake
// i_in      in   radicand[31:0], degree   valid/ready, sink modport
// o_out     out  root[31:0], status[1:0]  valid/ready, source modport
//
// An item of degree n runs ITERATIONS Newton steps; a rejected item skips them. Each Newton
// step spends n-1 products on the power multiplier and two passes through the shared
// one-bit-a-cycle divider. A step whose power underflows to zero skips the first pass.
// One item is worked on at a time; the next is accepted once the result register takes it.
// A stalled sink holds the result; reset is synchronous and active low.
//
// Top level of the n-th root block. Depends on nrn_pkg, nrn_ifs, nrn_ctrl and nrn_dp.
module nth_root_newton (
    input logic        i_clk,
    input logic        i_rst_n,
    nrn_in_if.sink     i_in,
    nrn_out_if.source  o_out
);
    import nrn_pkg::*;

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    // Sequencer.
    nrn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Arithmetic and result register.
    nrn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_ready (o_out.ready)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_data;

endmodule

FILE: design/nrn_chk.sv
// Port-level checker of the n-th root block, bound to the top level.
// Depends on nrn_pkg and the macros in nth_root_newton_defines.svh.
`include "nth_root_newton_defines.svh"

module nrn_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [nrn_pkg::WORD_W-1:0] i_root,
    input logic [nrn_pkg::STAT_W-1:0] i_status
);
    import nrn_pkg::*;

    // A result waiting on the sink stays offered and unchanged.
    `NRN_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result item dropped")
    `NRN_ASSERT_NXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_root) && $stable(i_status), "stalled result item changed")

    // Only one item is in work at a time.
    `NRN_ASSERT_NXT(a_one_item, i_in_valid && i_in_ready, !i_in_ready, "second item accepted while busy")

    // Rejected items report a zero root, and an offered status is always a defined code.
    `NRN_ASSERT_IMP(a_inval_root, i_out_valid && (i_status == ST_INVALID), i_root == '0, "invalid item with nonzero root")
    `NRN_ASSERT_IMP(a_status_code, i_out_valid, (i_status == ST_OK) || (i_status == ST_INVALID) || (i_status == ST_SAT), "undefined status code")

endmodule

bind nth_root_newton nrn_chk u_nrn_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_root      (o_out.data.root),
    .i_status    (o_out.data.status)
);
